// ----- src/jddm_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive mixer package
// Types, register indexes and output codes shared by the drive mixer files.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_STICK_CENTER   = 3'd0;
  localparam logic [2:0] REG_DEAD_BAND      = 3'd1;
  localparam logic [2:0] REG_LINK_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_OBSTACLE_LIMIT = 3'd3;
  localparam logic [2:0] REG_TURN_CUT       = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX      = 3'd5;
  localparam logic [2:0] REG_SPIN_MAX       = 3'd6;

  // Bridge pin patterns, IN1..IN4 on bit 3..bit 0
  localparam logic [3:0] PINS_STOP   = 4'b0000;
  localparam logic [3:0] PINS_FWD    = 4'b1010;
  localparam logic [3:0] PINS_BACK   = 4'b0101;
  localparam logic [3:0] PINS_SPIN_R = 4'b1001;
  localparam logic [3:0] PINS_SPIN_L = 4'b0110;

  // Drive status codes
  localparam logic [2:0] ST_DRIVE = 3'd0;
  localparam logic [2:0] ST_SPIN  = 3'd1;
  localparam logic [2:0] ST_DEAD  = 3'd2;
  localparam logic [2:0] ST_OBST  = 3'd3;
  localparam logic [2:0] ST_FAIL  = 3'd4;
  localparam logic [2:0] ST_HELD  = 3'd5;

  // Item operations
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  typedef struct packed {
    logic [11:0] stick_center;
    logic [11:0] dead_band;
    logic [15:0] link_timeout;
    logic [9:0]  obstacle_limit;
    logic [9:0]  turn_cut;
    logic [9:0]  drive_max;
    logic [9:0]  spin_max;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] joy_drive;
    logic signed [15:0] joy_turn;
    logic [9:0]         obstacle_cm;
  } item_t;

  typedef struct packed {
    logic [3:0] pins;
    logic [9:0] left;
    logic [9:0] right;
  } hold_t;

  typedef struct packed {
    logic [3:0] bridge_pins;
    logic [9:0] left_duty;
    logic [9:0] right_duty;
    logic [2:0] drive_status;
  } result_t;

endpackage

// ----- src/jddm_if.sv -----
// ----------------------------------------------------------------------------
// Drive mixer channels
// Valid/ready channels for joystick items and for bridge results.
// ----------------------------------------------------------------------------
interface jddm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] joy_drive;
  logic signed [15:0] joy_turn;
  logic [9:0]         obstacle_cm;

  modport source (output valid, operation, joy_drive, joy_turn, obstacle_cm,
                  input ready);
  modport sink (input valid, operation, joy_drive, joy_turn, obstacle_cm,
                output ready);
endinterface

interface jddm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] bridge_pins;
  logic [9:0] left_duty;
  logic [9:0] right_duty;
  logic [2:0] drive_status;

  modport source (output valid, bridge_pins, left_duty, right_duty, drive_status,
                  input ready);
  modport sink (input valid, bridge_pins, left_duty, right_duty, drive_status,
                output ready);
endinterface

// ----- src/jddm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Drive mixer configuration registers
// Write-only register file holding the mixer settings.
// ----------------------------------------------------------------------------
module jddm_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [15:0]     wr_data,
  output jddm_pkg::cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_center   <= 12'd500;
      cfg.dead_band      <= 12'd100;
      cfg.link_timeout   <= 16'd500;
      cfg.obstacle_limit <= 10'd20;
      cfg.turn_cut       <= 10'd200;
      cfg.drive_max      <= 10'd1000;
      cfg.spin_max       <= 10'd800;
    end else if (wr_en) begin
      case (wr_index)
        jddm_pkg::REG_STICK_CENTER:   cfg.stick_center   <= wr_data[11:0];
        jddm_pkg::REG_DEAD_BAND:      cfg.dead_band      <= wr_data[11:0];
        jddm_pkg::REG_LINK_TIMEOUT:   cfg.link_timeout   <= wr_data;
        jddm_pkg::REG_OBSTACLE_LIMIT: cfg.obstacle_limit <= wr_data[9:0];
        jddm_pkg::REG_TURN_CUT:       cfg.turn_cut       <= wr_data[9:0];
        jddm_pkg::REG_DRIVE_MAX:      cfg.drive_max      <= wr_data[9:0];
        jddm_pkg::REG_SPIN_MAX:       cfg.spin_max       <= wr_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/jddm_mixer.sv -----
// ----------------------------------------------------------------------------
// Drive mixer datapath
// Decides the bridge pattern and wheel duties for one item.
// ----------------------------------------------------------------------------
module jddm_mixer #(
  parameter int DUTY_BITS   = 10,
  parameter int SCALE_SHIFT = 11
) (
  input  jddm_pkg::item_t   item,
  input  jddm_pkg::cfg_t    cfg,
  input  jddm_pkg::hold_t   held,
  input  logic [15:0]       silence,
  output jddm_pkg::result_t res,
  output logic [15:0]       silence_next
);

  localparam logic [16:0] DUTY_TOP = 17'((1 << DUTY_BITS) - 1);

  logic [16:0] center;
  logic [16:0] dx_s;
  logic [16:0] dy_s;
  logic [16:0] dx_mag;
  logic [16:0] dy_mag;
  logic [15:0] dx;
  logic [15:0] dy;
  logic        x_above;
  logic        y_above;
  logic        x_quiet;
  logic        y_quiet;
  logic        spin;
  logic [15:0] dev;
  logic [9:0]  maxv;
  logic [25:0] prod;
  logic [25:0] scaled;
  logic [9:0]  spd_lim;
  logic [9:0]  spd;
  logic [9:0]  cut_spd;
  logic [15:0] silence_inc;
  logic        fail;

  // Axis deviations from the centre, in 17-bit two's complement.
  assign center = {5'd0, cfg.stick_center};
  assign dx_s   = {item.joy_drive[15], item.joy_drive} - center;
  assign dy_s   = {item.joy_turn[15], item.joy_turn} - center;
  assign dx_mag = dx_s[16] ? (17'd0 - dx_s) : dx_s;
  assign dy_mag = dy_s[16] ? (17'd0 - dy_s) : dy_s;
  assign dx     = dx_mag[15:0];
  assign dy     = dy_mag[15:0];

  assign x_above = !dx_s[16] && (dx_s != 17'd0);
  assign y_above = !dy_s[16] && (dy_s != 17'd0);
  assign x_quiet = dx <= {4'd0, cfg.dead_band};
  assign y_quiet = dy <= {4'd0, cfg.dead_band};
  assign spin    = x_quiet && !y_quiet;

  // One shared multiplier serves both the spin and the drive speed.
  assign dev     = spin ? dy : dx;
  assign maxv    = spin ? cfg.spin_max : cfg.drive_max;
  assign prod    = {10'd0, dev} * {16'd0, maxv};
  assign scaled  = prod >> SCALE_SHIFT;
  assign spd_lim = (scaled > {16'd0, maxv}) ? maxv : scaled[9:0];
  assign spd     = ({7'd0, spd_lim} > DUTY_TOP) ? DUTY_TOP[9:0] : spd_lim;
  assign cut_spd = (spd > cfg.turn_cut) ? (spd - cfg.turn_cut) : 10'd0;

  assign silence_inc = (silence != 16'hFFFF) ? (silence + 16'd1) : silence;
  assign fail        = silence_inc > cfg.link_timeout;

  always_comb begin
    res.bridge_pins  = held.pins;
    res.left_duty    = held.left;
    res.right_duty   = held.right;
    res.drive_status = jddm_pkg::ST_HELD;
    silence_next     = 16'd0;
    if (item.operation == jddm_pkg::OP_TICK) begin
      silence_next = silence_inc;
      if (fail) begin
        res.bridge_pins  = jddm_pkg::PINS_STOP;
        res.left_duty    = 10'd0;
        res.right_duty   = 10'd0;
        res.drive_status = jddm_pkg::ST_FAIL;
      end
    end else if (spin) begin
      res.bridge_pins  = y_above ? jddm_pkg::PINS_SPIN_R : jddm_pkg::PINS_SPIN_L;
      res.left_duty    = spd;
      res.right_duty   = spd;
      res.drive_status = jddm_pkg::ST_SPIN;
    end else if (x_quiet) begin
      res.bridge_pins  = jddm_pkg::PINS_STOP;
      res.left_duty    = 10'd0;
      res.right_duty   = 10'd0;
      res.drive_status = jddm_pkg::ST_DEAD;
    end else if (x_above && (item.obstacle_cm < cfg.obstacle_limit)) begin
      res.bridge_pins  = jddm_pkg::PINS_STOP;
      res.left_duty    = 10'd0;
      res.right_duty   = 10'd0;
      res.drive_status = jddm_pkg::ST_OBST;
    end else begin
      res.bridge_pins  = x_above ? jddm_pkg::PINS_FWD : jddm_pkg::PINS_BACK;
      res.left_duty    = (!y_quiet && !y_above) ? cut_spd : spd;
      res.right_duty   = (!y_quiet && y_above) ? cut_spd : spd;
      res.drive_status = jddm_pkg::ST_DRIVE;
    end
  end

endmodule

// ----- src/joystick_differential_drive_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// Joystick differential drive mixer
// Every transfer on the item channel is either a one-millisecond tick or a
// joystick packet, and each one produces exactly one result transfer that
// carries the H-bridge pin pattern, the two wheel duties and a status code.
// A packet measures both axes from the stick centre: the turn axis alone
// outside the dead band spins the chassis in place, a drive axis inside the
// dead band stops it, forward motion stops when the obstacle is nearer than
// the limit, and otherwise the chassis drives forward or backward with the
// inner wheel slowed by the turn cut. Ticks count silence on the link; once
// the count passes the timeout the motors stop, and the next packet resumes
// control. The block sustains one transfer per clock while the result side
// keeps up: an item is captured in an input register, and the decision and
// the single multiplier that scales the speed sit between that register and
// the result register, from which the result is offered; a new item is taken
// every cycle while the result side keeps up. Settings must be written
// through the plain write port only while no item is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit #(
  parameter int DUTY_BITS   = 10,
  parameter int SCALE_SHIFT = 11
) (
  input  logic        clk,
  input  logic        rst,
  jddm_in_if.sink     item,
  jddm_out_if.source  result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  jddm_pkg::cfg_t    cfg;

  // Input register stage.
  logic              s1_valid;
  jddm_pkg::item_t   s1_item;

  // Result register stage and the state that the next item sees.
  logic              out_valid;
  jddm_pkg::result_t out_res;
  jddm_pkg::hold_t   held;
  logic [15:0]       silence;

  jddm_pkg::result_t mix_res;
  logic [15:0]       silence_next;
  logic              take;
  logic              advance;

  jddm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  jddm_mixer #(
    .DUTY_BITS   (DUTY_BITS),
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_mixer (
    .item         (s1_item),
    .cfg          (cfg),
    .held         (held),
    .silence      (silence),
    .res          (mix_res),
    .silence_next (silence_next)
  );

  // The staged item moves into the result register whenever that register
  // is empty or its content is being taken in the same cycle. The input
  // side is ready whenever the input register is empty or moving on, so a
  // waiting result alone does not stop the next item from being captured.
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.operation   <= item.operation;
      s1_item.joy_drive   <= item.joy_drive;
      s1_item.joy_turn    <= item.joy_turn;
      s1_item.obstacle_cm <= item.obstacle_cm;
    end
  end

  // The held outputs and the silence counter change exactly when an item
  // completes, which keeps them in step with the order of results.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= '0;
      silence   <= 16'd0;
    end else begin
      out_valid <= advance || (out_valid && !result.ready);
      if (advance) begin
        held.pins  <= mix_res.bridge_pins;
        held.left  <= mix_res.left_duty;
        held.right <= mix_res.right_duty;
        silence    <= silence_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= mix_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.bridge_pins  = out_res.bridge_pins;
  assign result.left_duty    = out_res.left_duty;
  assign result.right_duty   = out_res.right_duty;
  assign result.drive_status = out_res.drive_status;

`ifndef SYNTH
  // Every stop outcome drives the bridge off with zero duty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.drive_status == jddm_pkg::ST_DEAD ||
                  out_res.drive_status == jddm_pkg::ST_OBST ||
                  out_res.drive_status == jddm_pkg::ST_FAIL)
    |-> out_res.bridge_pins == jddm_pkg::PINS_STOP &&
        out_res.left_duty == 10'd0 && out_res.right_duty == 10'd0)
    else $error("stop outcome with motors driven");

  // A spin drives both wheels alike in one of the two spin patterns.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.drive_status == jddm_pkg::ST_SPIN
    |-> (out_res.bridge_pins == jddm_pkg::PINS_SPIN_R ||
         out_res.bridge_pins == jddm_pkg::PINS_SPIN_L) &&
        out_res.left_duty == out_res.right_duty)
    else $error("spin with unequal duties or wrong pins");

  // The held state always matches the result last produced.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held.pins == out_res.bridge_pins &&
                  held.left == out_res.left_duty &&
                  held.right == out_res.right_duty)
    else $error("held outputs out of step with result register");

  // A completed packet clears the silence counter.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.operation == jddm_pkg::OP_PACKET |=> silence == 16'd0)
    else $error("silence counter not cleared by packet");

  // A staged item that cannot move on stays staged.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("staged item lost while result side stalled");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive mixer testbench
// Drives ticks and joystick packets into the drive mixer under random flow
// control on both channels. A scoreboard predicts every bridge result from
// its own copy of the settings and the held outputs and checks them in order.
// ----------------------------------------------------------------------------

class drive_mix_scoreboard;
  localparam int DUTY_BITS   = 10;
  localparam int SCALE_SHIFT = 11;
  localparam int unsigned DUTY_TOP = (1 << DUTY_BITS) - 1;

  jddm_pkg::cfg_t    cfg;
  logic [15:0]       silence;
  jddm_pkg::hold_t   held;
  jddm_pkg::result_t expected_q[$];
  int                checked;

  function new();
    cfg.stick_center   = 12'd500;
    cfg.dead_band      = 12'd100;
    cfg.link_timeout   = 16'd500;
    cfg.obstacle_limit = 10'd20;
    cfg.turn_cut       = 10'd200;
    cfg.drive_max      = 10'd1000;
    cfg.spin_max       = 10'd800;
    silence = '0;
    held    = '0;
    checked = 0;
  endfunction

  function void set_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      jddm_pkg::REG_STICK_CENTER:   cfg.stick_center   = val[11:0];
      jddm_pkg::REG_DEAD_BAND:      cfg.dead_band      = val[11:0];
      jddm_pkg::REG_LINK_TIMEOUT:   cfg.link_timeout   = val;
      jddm_pkg::REG_OBSTACLE_LIMIT: cfg.obstacle_limit = val[9:0];
      jddm_pkg::REG_TURN_CUT:       cfg.turn_cut       = val[9:0];
      jddm_pkg::REG_DRIVE_MAX:      cfg.drive_max      = val[9:0];
      jddm_pkg::REG_SPIN_MAX:       cfg.spin_max       = val[9:0];
      default: ;
    endcase
  endfunction

  // Deviation times the scale factor, shifted down, then clamped to the
  // factor itself and to the duty range.
  function int unsigned scaled_speed(int unsigned dev, int unsigned maxv);
    int unsigned s;
    s = (dev * maxv) >> SCALE_SHIFT;
    if (s > maxv) s = maxv;
    if (s > DUTY_TOP) s = DUTY_TOP;
    return s;
  endfunction

  function void hold_outputs(logic [3:0] pins, int unsigned l, int unsigned r);
    held.pins  = pins;
    held.left  = l[9:0];
    held.right = r[9:0];
  endfunction

  function void note_item(jddm_pkg::item_t it);
    jddm_pkg::result_t want;
    int                centre, x, y;
    int unsigned       dx, dy, band, sp, l, r, cut;
    logic [2:0]        status;

    if (it.operation == jddm_pkg::OP_TICK) begin
      if (silence != 16'hFFFF) silence = silence + 16'd1;
      if (silence > cfg.link_timeout) begin
        hold_outputs(jddm_pkg::PINS_STOP, 0, 0);
        status = jddm_pkg::ST_FAIL;
      end else begin
        status = jddm_pkg::ST_HELD;
      end
    end else begin
      centre  = int'(cfg.stick_center);
      x       = int'(it.joy_drive);
      y       = int'(it.joy_turn);
      dx      = (x >= centre) ? x - centre : centre - x;
      dy      = (y >= centre) ? y - centre : centre - y;
      band    = 32'(cfg.dead_band);
      cut     = 32'(cfg.turn_cut);
      silence = '0;
      if (dx <= band && dy > band) begin
        sp = scaled_speed(dy, 32'(cfg.spin_max));
        hold_outputs((y > centre) ? jddm_pkg::PINS_SPIN_R : jddm_pkg::PINS_SPIN_L, sp, sp);
        status = jddm_pkg::ST_SPIN;
      end else if (dx <= band) begin
        hold_outputs(jddm_pkg::PINS_STOP, 0, 0);
        status = jddm_pkg::ST_DEAD;
      end else if (x > centre && it.obstacle_cm < cfg.obstacle_limit) begin
        hold_outputs(jddm_pkg::PINS_STOP, 0, 0);
        status = jddm_pkg::ST_OBST;
      end else begin
        sp = scaled_speed(dx, 32'(cfg.drive_max));
        l  = sp;
        r  = sp;
        if (dy > band) begin
          if (y > centre) r = (r > cut) ? r - cut : 32'd0;
          else            l = (l > cut) ? l - cut : 32'd0;
        end
        hold_outputs((x > centre) ? jddm_pkg::PINS_FWD : jddm_pkg::PINS_BACK, l, r);
        status = jddm_pkg::ST_DRIVE;
      end
    end
    want.bridge_pins  = held.pins;
    want.left_duty    = held.left;
    want.right_duty   = held.right;
    want.drive_status = status;
    expected_q.push_back(want);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Returns the number of wrong fields; msg describes them.
  function int check_result(jddm_pkg::result_t got, output string msg);
    jddm_pkg::result_t want;
    int                bad;
    bad = 0;
    msg = "";
    checked++;
    if (expected_q.size() == 0) begin
      msg = $sformatf("result %0d arrived with nothing expected: pins %b L %0d R %0d st %0d",
                      checked, got.bridge_pins, got.left_duty, got.right_duty,
                      got.drive_status);
      return 1;
    end
    want = expected_q.pop_front();
    if (got.bridge_pins !== want.bridge_pins) begin
      bad++;
      msg = {msg, $sformatf(" pins %b/%b", got.bridge_pins, want.bridge_pins)};
    end
    if (got.left_duty !== want.left_duty) begin
      bad++;
      msg = {msg, $sformatf(" left %0d/%0d", got.left_duty, want.left_duty)};
    end
    if (got.right_duty !== want.right_duty) begin
      bad++;
      msg = {msg, $sformatf(" right %0d/%0d", got.right_duty, want.right_duty)};
    end
    if (got.drive_status !== want.drive_status) begin
      bad++;
      msg = {msg, $sformatf(" status %0d/%0d", got.drive_status, want.drive_status)};
    end
    if (bad != 0) msg = {$sformatf("result %0d (got/expected):", checked), msg};
    return bad;
  endfunction
endclass

module tb_top;

  // Cycles the receiver refuses results while the sender keeps offering items.
  localparam int HOLD_OFF_CYCLES = 40;
  // Cycles allowed after the last expected result, covering the two-stage path.
  localparam int SETTLE_CYCLES   = 6;
  // Absolute run limit in ns, several times the slowest legal run.
  localparam int RUN_LIMIT_NS    = 200000;
  localparam int PHASE_ITEMS     = 240;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  jddm_in_if  item_ch ();
  jddm_out_if res_ch ();

  joystick_differential_drive_mixer_unit #(
    .DUTY_BITS   (10),
    .SCALE_SHIFT (11)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  drive_mix_scoreboard sb;
  jddm_pkg::cfg_t      cur_cfg;

  int errors          = 0;
  int items_sent      = 0;
  int packets_sent    = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;

  // Random idling on both channels is switched per phase; the hold-off
  // request is raised by the stimulus and cleared by the receiver process.
  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results still outstanding.", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Ready is decided at every rising edge. Most of the time it
  // is high; while idling is enabled it drops for short bursts, and once in
  // the run it is held low for a long counted stretch so that the pipeline
  // fills and the item channel backs up.
  // --------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction. Values
  // read here are those that stood before the edge.
  always @(posedge clk) begin : result_monitor
    jddm_pkg::result_t got;
    string             msg;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.bridge_pins  = res_ch.bridge_pins;
      got.left_duty    = res_ch.left_duty;
      got.right_duty   = res_ch.right_duty;
      got.drive_status = res_ch.drive_status;
      results_checked++;
      if (sb.check_result(got, msg) != 0) report_error(msg);
    end
  end

  // --------------------------------------------------------------------------
  // Item side. Valid stays high from one item to the next unless an idle
  // burst is drawn, so back-to-back transfers happen whenever the block is
  // ready. The item is handed to the scoreboard at the edge of its transfer.
  // --------------------------------------------------------------------------
  task automatic send_item(input jddm_pkg::item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= it.operation;
    item_ch.joy_drive   <= it.joy_drive;
    item_ch.joy_turn    <= it.joy_turn;
    item_ch.obstacle_cm <= it.obstacle_cm;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_packet(input int drive, input int turn, input int obst);
    jddm_pkg::item_t it;
    it.operation   = jddm_pkg::OP_PACKET;
    it.joy_drive   = drive[15:0];
    it.joy_turn    = turn[15:0];
    it.obstacle_cm = obst[9:0];
    packets_sent++;
    send_item(it);
  endtask

  // A tick carries random payload, which the block must not look at.
  task automatic send_tick();
    jddm_pkg::item_t it;
    int unsigned     junk;
    junk           = $urandom;
    it.operation   = jddm_pkg::OP_TICK;
    it.joy_drive   = junk[15:0];
    it.joy_turn    = junk[31:16];
    junk           = $urandom;
    it.obstacle_cm = junk[9:0];
    ticks_sent++;
    send_item(it);
  endtask

  // Drops valid and waits until every predicted result has been taken, then
  // waits out the settle time so that nothing is left inside the block.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    sb.set_register(idx, val);
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // All seven registers are rewritten for every new setting.
  task automatic load_config(input jddm_pkg::cfg_t c);
    write_reg(jddm_pkg::REG_STICK_CENTER,   16'(c.stick_center));
    write_reg(jddm_pkg::REG_DEAD_BAND,      16'(c.dead_band));
    write_reg(jddm_pkg::REG_LINK_TIMEOUT,   c.link_timeout);
    write_reg(jddm_pkg::REG_OBSTACLE_LIMIT, 16'(c.obstacle_limit));
    write_reg(jddm_pkg::REG_TURN_CUT,       16'(c.turn_cut));
    write_reg(jddm_pkg::REG_DRIVE_MAX,      16'(c.drive_max));
    write_reg(jddm_pkg::REG_SPIN_MAX,       16'(c.spin_max));
    cur_cfg = c;
    settings_used++;
  endtask

  // Most settings use a narrow dead band and a short link timeout so that
  // all outcomes and the failsafe show up often; now and then either one is
  // drawn from its full range.
  function automatic jddm_pkg::cfg_t random_config();
    jddm_pkg::cfg_t c;
    c.stick_center   = 12'($urandom_range(0, 4095));
    c.dead_band      = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(0, 300));
    c.link_timeout   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65534))
                                                   : 16'($urandom_range(1, 40));
    c.obstacle_limit = 10'($urandom_range(0, 999));
    c.turn_cut       = 10'($urandom_range(0, 1023));
    c.drive_max      = 10'($urandom_range(0, 1023));
    c.spin_max       = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  // Axis values mostly fall around the centre so that the dead band edges
  // and both sides of it are hit; some sit right on the band edge and some
  // span the whole 16-bit range.
  function automatic int random_axis(input int centre, input int band);
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = int'($urandom_range(0, 65535));
      2:       v = centre + (($urandom_range(0, 1) != 0) ? band : -band)
                   + int'($urandom_range(0, 2)) - 1;
      default: v = centre + int'($urandom_range(0, 2 * (band + 600))) - (band + 600);
    endcase
    return v;
  endfunction

  function automatic int random_obstacle(input int lim);
    int v;
    case ($urandom_range(0, 5))
      0:       v = 999;
      1: begin
        v = lim + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 999) v = 999;
      end
      default: v = int'($urandom_range(0, 999));
    endcase
    return v;
  endfunction

  // One random phase under the current setting. Packets dominate; ticks come
  // singly or in runs long enough to trip the failsafe when the timeout is
  // short. Optionally the receiver holds off once, or the sender pauses once
  // until all outstanding results have arrived.
  task automatic random_phase(input int n_items, input bit do_hold_off, input bit do_pause);
    int count;
    int run_len;
    int top;
    bit hold_done;
    bit pause_done;
    count      = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (count < n_items) begin
      if (do_hold_off && !hold_done && count >= n_items / 3) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (do_pause && !pause_done && count >= n_items / 2) begin
        wait_drained();
        pause_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        6, 7, 8: begin
          send_tick();
          count++;
        end
        9: begin
          top = int'(cur_cfg.link_timeout) + 3;
          if (top > 60) top = 60;
          run_len = int'($urandom_range(1, top));
          repeat (run_len) send_tick();
          count += run_len;
        end
        default: begin
          send_packet(random_axis(int'(cur_cfg.stick_center), int'(cur_cfg.dead_band)),
                      random_axis(int'(cur_cfg.stick_center), int'(cur_cfg.dead_band)),
                      random_obstacle(int'(cur_cfg.obstacle_limit)));
          count++;
        end
      endcase
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    jddm_pkg::cfg_t c;

    sb = new();
    cur_cfg = sb.cfg;
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= jddm_pkg::REG_STICK_CENTER;
    wr_data             <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= jddm_pkg::OP_TICK;
    item_ch.joy_drive   <= '0;
    item_ch.joy_turn    <= '0;
    item_ch.obstacle_cm <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Directed items under the reset settings: centre 500, band 100,
    // limit 20, cut 200, drive scale 1000, spin scale 800.
    send_tick();                          // held outputs straight after reset
    send_packet(500, 500, 999);           // both axes neutral: dead band stop
    send_packet(500, 700, 999);           // turn alone: spin right
    send_packet(500, 300, 999);           // turn alone: spin left
    send_packet(600, 601, 999);           // drive on the band edge, turn just past it
    send_packet(601, 500, 999);           // drive just past the band: slow forward
    send_packet(32767, 500, 999);         // full forward, speed clamped to the scale
    send_packet(-32768, -32768, 0);       // full back with a near obstacle: not blocked
    send_packet(32767, 32767, 19);        // forward with obstacle inside the limit
    send_packet(32767, 32767, 20);        // obstacle right at the limit: drives
    send_packet(700, 700, 999);           // right wheel cut floors at zero
    send_packet(300, 300, 999);           // back, left wheel cut floors at zero
    send_tick();                          // tick within timeout repeats the last outputs
    send_packet(0, 0, 0);                 // back and turning left
    send_packet(-1, -1, 999);             // small negative axes
    wait_drained();

    // Directed items with a zero centre and band, a two-tick timeout and
    // every scale at its maximum.
    c.stick_center   = 12'd0;
    c.dead_band      = 12'd0;
    c.link_timeout   = 16'd2;
    c.obstacle_limit = 10'd999;
    c.turn_cut       = 10'd1023;
    c.drive_max      = 10'd1023;
    c.spin_max       = 10'd1023;
    load_config(c);
    send_packet(1, 0, 999);               // one count of drive scales to zero speed
    repeat (4) send_tick();               // two held, then failsafe twice
    send_packet(0, -32768, 999);          // packet after failsafe resumes: spin left
    send_tick();
    send_packet(-32768, 32767, 0);        // back, right wheel cut to zero
    send_packet(32767, 0, 998);           // forward blocked by an obstacle below 999
    wait_drained();

    // Random phases. The second holds off the receiver, the third runs with
    // no idling, the fourth pauses the sender until everything has drained.
    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);

    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b1, 1'b0);

    idle_on = 1'b0;
    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    idle_on = 1'b1;

    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b1);

    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);

    c = random_config();
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Every register at its low extreme: any deviation drives, at zero speed,
    // and a second silent tick trips the failsafe.
    c.stick_center   = 12'd0;
    c.dead_band      = 12'd0;
    c.link_timeout   = 16'd1;
    c.obstacle_limit = 10'd0;
    c.turn_cut       = 10'd0;
    c.drive_max      = 10'd0;
    c.spin_max       = 10'd0;
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Every register at its high extreme, no idling from here to the end.
    // A short tick run stays well inside the largest timeout, so the held
    // outputs keep repeating until the last packet.
    idle_on = 1'b0;
    c.stick_center   = 12'd4095;
    c.dead_band      = 12'd4095;
    c.link_timeout   = 16'd65534;
    c.obstacle_limit = 10'd999;
    c.turn_cut       = 10'd1023;
    c.drive_max      = 10'd1023;
    c.spin_max       = 10'd1023;
    load_config(c);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    send_packet(32767, 4095, 999);
    repeat (20) send_tick();
    send_packet(-32768, 32767, 999);
    wait_drained();

    $display("Run covered %0d items (%0d packets, %0d ticks) and %0d checked results.",
             items_sent, packets_sent, ticks_sent, results_checked);
    $display("It used %0d register settings, both extremes included, with flow stalls.",
             settings_used);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
